/* design/tree_lca_binary_lifting_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the lowest common ancestor block
// Checks are compiled for simulation and drop out for synthesis.
// ----------------------------------------------------------------------------
`ifndef TREE_LCA_BINARY_LIFTING_DEFINES_SVH
`define TREE_LCA_BINARY_LIFTING_DEFINES_SVH

`ifndef SYNTHESIS
// Implication checked on every rising clock edge outside reset.
`define TLCA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequence is checked in the next cycle.
`define TLCA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TLCA_ASSERT_IMP(lbl, ante, cons, msg)
`define TLCA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* design/tlca_pkg.sv */
// ----------------------------------------------------------------------------
// Lowest common ancestor package
// Field widths, request codes, item types and memory control bundle.
// ----------------------------------------------------------------------------
package tlca_pkg;

	// Widths fixed by the item format.
	localparam int FIELD_W = 10;
	localparam int DEPTH_W = 10;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = 10'd1023;

	// Default sizes of the tree tables.
	localparam int NODE_COUNT_DEF  = 1024;
	localparam int LIFT_LEVELS_DEF = 10;

	// Request codes.
	localparam logic REQ_ATTACH = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	// One input item.
	typedef struct packed {
		logic               req_type;
		logic [FIELD_W-1:0] node_a;
		logic [FIELD_W-1:0] node_b;
	} req_t;

	// One result item.
	typedef struct packed {
		logic [FIELD_W-1:0] ancestor;
		logic               is_answer;
	} rsp_t;

	// Enables from the sequencer to the table memory.
	typedef struct packed {
		logic wr_en;
		logic rd_en_a;
		logic rd_en_b;
	} mem_ctl_t;

endpackage

/* design/tlca_mem.sv */
// ----------------------------------------------------------------------------
// Tree table memory
// One row per node holding its depth and all its lifting ancestors; one
// write port and two registered read ports that hold their data when idle.
// ----------------------------------------------------------------------------
module tlca_mem #(
	parameter int DEPTH  = tlca_pkg::NODE_COUNT_DEF,
	parameter int ADDR_W = $clog2(tlca_pkg::NODE_COUNT_DEF),
	parameter int DATA_W = 110
) (
	input  logic                  clk,
	input  tlca_pkg::mem_ctl_t    ctl,
	input  logic [ADDR_W-1:0]     wr_addr,
	input  logic [DATA_W-1:0]     wr_data,
	input  logic [ADDR_W-1:0]     rd_addr_a,
	input  logic [ADDR_W-1:0]     rd_addr_b,
	output logic [DATA_W-1:0]     rd_data_a,
	output logic [DATA_W-1:0]     rd_data_b
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_a_q;
	logic [DATA_W-1:0] rd_b_q;

	// Write port and two read ports; read data is held while not enabled.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en_a) begin
			rd_a_q <= mem_q[rd_addr_a];
		end
		if (ctl.rd_en_b) begin
			rd_b_q <= mem_q[rd_addr_b];
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

/* design/tlca_seq.sv */
// ----------------------------------------------------------------------------
// Lowest common ancestor sequencer
// Clears the table after reset, walks the lifting levels for attach and
// query items, and holds each result in an output register.
// ----------------------------------------------------------------------------
`include "tree_lca_binary_lifting_defines.svh"

module tlca_seq #(
	parameter int NODE_COUNT  = tlca_pkg::NODE_COUNT_DEF,
	parameter int LIFT_LEVELS = tlca_pkg::LIFT_LEVELS_DEF,
	parameter int NODE_W      = $clog2(NODE_COUNT),
	parameter int ROW_W       = tlca_pkg::DEPTH_W + LIFT_LEVELS * NODE_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  tlca_pkg::req_t      req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output tlca_pkg::rsp_t      rsp,
	output tlca_pkg::mem_ctl_t  mem_ctl,
	output logic [NODE_W-1:0]   wr_addr,
	output logic [ROW_W-1:0]    wr_data,
	output logic [NODE_W-1:0]   rd_addr_a,
	output logic [NODE_W-1:0]   rd_addr_b,
	input  logic [ROW_W-1:0]    rd_data_a,
	input  logic [ROW_W-1:0]    rd_data_b
);

	localparam int LVL_W = $clog2(LIFT_LEVELS);
	localparam int ANC_W = LIFT_LEVELS * NODE_W;
	localparam int DW    = tlca_pkg::DEPTH_W;

	localparam logic [3:0] ST_CLEAR     = 4'd0;
	localparam logic [3:0] ST_IDLE      = 4'd1;
	localparam logic [3:0] ST_ATT_WALK  = 4'd2;
	localparam logic [3:0] ST_ATT_WRITE = 4'd3;
	localparam logic [3:0] ST_Q_DEPTH   = 4'd4;
	localparam logic [3:0] ST_Q_LIFT    = 4'd5;
	localparam logic [3:0] ST_Q_CHECK   = 4'd6;
	localparam logic [3:0] ST_Q_CLIMB   = 4'd7;
	localparam logic [3:0] ST_Q_FINAL   = 4'd8;

	localparam logic [LVL_W-1:0]  LVL_TOP      = LVL_W'(LIFT_LEVELS - 1);
	localparam logic [LVL_W-1:0]  LVL_ATT_LAST = LVL_W'(LIFT_LEVELS - 2);
	localparam logic [NODE_W-1:0] NODE_LAST    = NODE_W'(NODE_COUNT - 1);

	// Node numbers at or beyond the table size map to the sentinel.
	function automatic logic [NODE_W-1:0] node_of(input logic [tlca_pkg::FIELD_W-1:0] v);
		node_of = (32'(v) < NODE_COUNT) ? NODE_W'(v) : '0;
	endfunction

	logic [3:0]             state_q, state_d;
	logic [LVL_W-1:0]       lvl_q, lvl_d;
	logic [NODE_W-1:0]      clr_q, clr_d;
	logic                   rsp_valid_q;
	tlca_pkg::rsp_t         rsp_q, rsp_d;
	logic                   rsp_load;
	logic [NODE_W-1:0]      node_a_q, node_a_d;
	logic [NODE_W-1:0]      node_b_q, node_b_d;
	logic                   deep_b_q, deep_b_d;
	logic [LIFT_LEVELS-1:0] k_q, k_d;
	logic [ANC_W-1:0]       row_q, row_d;
	logic [DW-1:0]          depth_new_q, depth_new_d;

	logic                   out_free;
	logic [NODE_W-1:0]      anc_a_lvl;
	logic [NODE_W-1:0]      anc_b_lvl;
	logic [NODE_W-1:0]      deep_anc;
	logic [NODE_W-1:0]      walk_val;
	logic [DW-1:0]          depth_a;
	logic [DW-1:0]          depth_b;
	logic                   b_deeper;
	logic [DW-1:0]          depth_diff;

	// Fields of the rows read from the table.
	assign anc_a_lvl  = rd_data_a[lvl_q * NODE_W +: NODE_W];
	assign anc_b_lvl  = rd_data_b[lvl_q * NODE_W +: NODE_W];
	assign deep_anc   = deep_b_q ? anc_b_lvl : anc_a_lvl;
	assign depth_a    = rd_data_a[ROW_W-1 -: DW];
	assign depth_b    = rd_data_b[ROW_W-1 -: DW];
	assign b_deeper   = depth_a < depth_b;
	assign depth_diff = b_deeper ? (depth_b - depth_a) : (depth_a - depth_b);

	// A row of the child being built is forwarded when the walk reaches it.
	assign walk_val = (node_b_q == node_a_q) ? node_b_q : anc_a_lvl;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);

	// Sequencer next state and memory commands.
	always_comb begin
		state_d     = state_q;
		lvl_d       = lvl_q;
		clr_d       = clr_q;
		node_a_d    = node_a_q;
		node_b_d    = node_b_q;
		deep_b_d    = deep_b_q;
		k_d         = k_q;
		row_d       = row_q;
		depth_new_d = depth_new_q;
		rsp_d       = rsp_q;
		rsp_load    = 1'b0;
		mem_ctl     = '0;
		wr_addr     = '0;
		wr_data     = '0;
		rd_addr_a   = '0;
		rd_addr_b   = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_ctl.wr_en = 1'b1;
				wr_addr       = clr_q;
				clr_d         = clr_q + NODE_W'(1);
				if (clr_q == NODE_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					node_a_d = node_of(req.node_a);
					node_b_d = node_of(req.node_b);
					if (req.req_type == tlca_pkg::REQ_ATTACH) begin
						// Read the parent row; level zero of the child is the parent.
						mem_ctl.rd_en_a = 1'b1;
						rd_addr_a       = node_of(req.node_b);
						row_d[NODE_W-1:0] = node_of(req.node_b);
						lvl_d   = '0;
						state_d = ST_ATT_WALK;
					end else begin
						mem_ctl.rd_en_a = 1'b1;
						mem_ctl.rd_en_b = 1'b1;
						rd_addr_a       = node_of(req.node_a);
						rd_addr_b       = node_of(req.node_b);
						state_d         = ST_Q_DEPTH;
					end
				end
			end
			ST_ATT_WALK: begin
				// The row in hand belongs to the child's ancestor at level lvl.
				if (lvl_q == '0) begin
					depth_new_d = (depth_a == tlca_pkg::DEPTH_MAX) ?
						depth_a : depth_a + DW'(1);
				end
				row_d[(lvl_q + 1) * NODE_W +: NODE_W] = walk_val;
				node_b_d        = walk_val;
				mem_ctl.rd_en_a = 1'b1;
				rd_addr_a       = walk_val;
				if (lvl_q == LVL_ATT_LAST) begin
					state_d = ST_ATT_WRITE;
				end else begin
					lvl_d = lvl_q + LVL_W'(1);
				end
			end
			ST_ATT_WRITE: begin
				if (out_free) begin
					// The sentinel row is never overwritten.
					mem_ctl.wr_en   = (node_a_q != '0);
					wr_addr         = node_a_q;
					wr_data         = {depth_new_q, row_q};
					rsp_load        = 1'b1;
					rsp_d.ancestor  = '0;
					rsp_d.is_answer = 1'b0;
					state_d         = ST_IDLE;
				end
			end
			ST_Q_DEPTH: begin
				deep_b_d = b_deeper;
				k_d      = LIFT_LEVELS'(depth_diff);
				lvl_d    = LVL_TOP;
				state_d  = ST_Q_LIFT;
			end
			ST_Q_LIFT: begin
				// Lift the deeper node by the set bits of the depth difference.
				if (k_q[lvl_q]) begin
					if (deep_b_q) begin
						node_b_d        = deep_anc;
						mem_ctl.rd_en_b = 1'b1;
						rd_addr_b       = deep_anc;
					end else begin
						node_a_d        = deep_anc;
						mem_ctl.rd_en_a = 1'b1;
						rd_addr_a       = deep_anc;
					end
				end
				if (lvl_q == '0) begin
					state_d = ST_Q_CHECK;
				end else begin
					lvl_d = lvl_q - LVL_W'(1);
				end
			end
			ST_Q_CHECK: begin
				if (node_a_q == node_b_q) begin
					if (out_free) begin
						rsp_load        = 1'b1;
						rsp_d.ancestor  = tlca_pkg::FIELD_W'(node_a_q);
						rsp_d.is_answer = 1'b1;
						state_d         = ST_IDLE;
					end
				end else begin
					lvl_d   = LVL_TOP;
					state_d = ST_Q_CLIMB;
				end
			end
			ST_Q_CLIMB: begin
				// Climb both nodes while their ancestors at this level differ.
				if (anc_a_lvl != anc_b_lvl) begin
					node_a_d        = anc_a_lvl;
					node_b_d        = anc_b_lvl;
					mem_ctl.rd_en_a = 1'b1;
					mem_ctl.rd_en_b = 1'b1;
					rd_addr_a       = anc_a_lvl;
					rd_addr_b       = anc_b_lvl;
				end
				if (lvl_q == '0) begin
					state_d = ST_Q_FINAL;
				end else begin
					lvl_d = lvl_q - LVL_W'(1);
				end
			end
			ST_Q_FINAL: begin
				if (out_free) begin
					// The answer is the parent of the climbed node on the side that started out deeper.
					rsp_load        = 1'b1;
					rsp_d.ancestor  = tlca_pkg::FIELD_W'(deep_b_q ?
						rd_data_b[NODE_W-1:0] : rd_data_a[NODE_W-1:0]);
					rsp_d.is_answer = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			lvl_q       <= '0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			lvl_q   <= lvl_d;
			clr_q   <= clr_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the item in progress and the result register.
	always_ff @(posedge clk) begin
		node_a_q    <= node_a_d;
		node_b_q    <= node_b_d;
		deep_b_q    <= deep_b_d;
		k_q         <= k_d;
		row_q       <= row_d;
		depth_new_q <= depth_new_d;
		rsp_q       <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`TLCA_ASSERT_IMP(a_no_rd_on_wr, mem_ctl.wr_en, !mem_ctl.rd_en_a && !mem_ctl.rd_en_b, "table read during a write")
	`TLCA_ASSERT_IMP(a_sentinel_kept, mem_ctl.wr_en && state_q != ST_CLEAR, wr_addr != '0, "sentinel row overwritten")
	`TLCA_ASSERT_NXT(a_item_started, req_valid && req_ready, state_q == ST_ATT_WALK || state_q == ST_Q_DEPTH, "accepted item did not start")
	`TLCA_ASSERT_IMP(a_result_source, rsp_load, state_q == ST_ATT_WRITE || state_q == ST_Q_CHECK || state_q == ST_Q_FINAL, "result loaded outside a final step")

endmodule

/* design/tree_lca_binary_lifting.sv */
// ----------------------------------------------------------------------------
// Lowest common ancestor by binary lifting
// Attach and query items over a rooted tree kept in one row-per-node memory.
// ----------------------------------------------------------------------------
// Attach: the walk reads one row per lifting level, then writes the child's row.
// Query: a depth step, a lift phase over every lifting level and a check; unless
//   the lift alone meets the other node, a climb phase over every level and a final
//   step follow. Each item finishes before the next is taken.
// A new item is taken while the previous result still waits in its register.
// After reset a clearing pass writes zero to every row.
// ----------------------------------------------------------------------------
module tree_lca_binary_lifting #(
	parameter int NODE_COUNT  = tlca_pkg::NODE_COUNT_DEF,
	parameter int LIFT_LEVELS = tlca_pkg::LIFT_LEVELS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  tlca_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output tlca_pkg::rsp_t rsp
);

	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int ROW_W  = tlca_pkg::DEPTH_W + LIFT_LEVELS * NODE_W;

	tlca_pkg::mem_ctl_t mem_ctl;
	logic [NODE_W-1:0]  wr_addr;
	logic [ROW_W-1:0]   wr_data;
	logic [NODE_W-1:0]  rd_addr_a;
	logic [NODE_W-1:0]  rd_addr_b;
	logic [ROW_W-1:0]   rd_data_a;
	logic [ROW_W-1:0]   rd_data_b;

	// Sequencer for attach and query items.
	tlca_seq #(
		.NODE_COUNT (NODE_COUNT),
		.LIFT_LEVELS(LIFT_LEVELS),
		.NODE_W     (NODE_W),
		.ROW_W      (ROW_W)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.mem_ctl  (mem_ctl),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b)
	);

	// Depth and lifting table, one row per node.
	tlca_mem #(
		.DEPTH (NODE_COUNT),
		.ADDR_W(NODE_W),
		.DATA_W(ROW_W)
	) u_mem (
		.clk      (clk),
		.ctl      (mem_ctl),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b)
	);

endmodule

/* tb/sv/tlca_tb_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lowest common ancestor scoreboard
// Keeps its own copy of the depth and lifting tables, predicts the result of
// every accepted item and checks the results in order of arrival.
// ----------------------------------------------------------------------------
package tlca_tb_pkg;

	import tlca_pkg::*;

	// Only the first few mismatches are printed in full.
	localparam int MAX_REPORTS = 10;

	class lca_scoreboard;

		logic [DEPTH_W-1:0] depth_mem [NODE_COUNT_DEF];
		logic [FIELD_W-1:0] up_mem [NODE_COUNT_DEF][LIFT_LEVELS_DEF];
		rsp_t               pending_answers [$];
		int                 n_checked;
		int                 n_mismatch;
		int                 deepest;

		// Both tables start at zero, which makes node zero the sentinel.
		function new();
			for (int n = 0; n < NODE_COUNT_DEF; n++) begin
				depth_mem[n] = '0;
				for (int j = 0; j < LIFT_LEVELS_DEF; j++)
					up_mem[n][j] = '0;
			end
			n_checked  = 0;
			n_mismatch = 0;
			deepest    = 0;
		endfunction

		// Hang a child under a parent; node zero is never overwritten.
		function void hang_child(int child, int parent);
			int d;
			if (child == 0)
				return;
			d = int'(depth_mem[parent]) + 1;
			if (d > int'(DEPTH_MAX))
				d = int'(DEPTH_MAX);
			if (d > deepest)
				deepest = d;
			depth_mem[child] = d[DEPTH_W-1:0];
			up_mem[child][0] = parent[FIELD_W-1:0];
			for (int j = 1; j < LIFT_LEVELS_DEF; j++)
				up_mem[child][j] = up_mem[up_mem[child][j-1]][j-1];
		endfunction

		// Lift the deeper node level with the other, then climb both together.
		function logic [FIELD_W-1:0] lowest_common(int a, int b);
			int t;
			int k;
			if (depth_mem[a] < depth_mem[b]) begin
				t = a;
				a = b;
				b = t;
			end
			k = (int'(depth_mem[a]) - int'(depth_mem[b])) & ((1 << LIFT_LEVELS_DEF) - 1);
			for (int i = LIFT_LEVELS_DEF - 1; i >= 0; i--)
				if (k[i])
					a = int'(up_mem[a][i]);
			if (a == b)
				return a[FIELD_W-1:0];
			for (int i = LIFT_LEVELS_DEF - 1; i >= 0; i--) begin
				if (up_mem[a][i] != up_mem[b][i]) begin
					a = int'(up_mem[a][i]);
					b = int'(up_mem[b][i]);
				end
			end
			return up_mem[a][0];
		endfunction

		// Every node number of ten bits is in range at 1024 nodes.
		function void note_request(req_t r);
			rsp_t want;
			if (r.req_type == REQ_ATTACH) begin
				hang_child(int'(r.node_a), int'(r.node_b));
				want.ancestor  = '0;
				want.is_answer = 1'b0;
			end else begin
				want.ancestor  = lowest_common(int'(r.node_a), int'(r.node_b));
				want.is_answer = 1'b1;
			end
			pending_answers = {pending_answers, want};
		endfunction

		// Compare a result with the oldest outstanding prediction.
		function void check_response(rsp_t got);
			rsp_t want;
			n_checked++;
			if (pending_answers.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= MAX_REPORTS)
					$display("ERROR: result with no item outstanding: ancestor=%0d is_answer=%0d",
						got.ancestor, got.is_answer);
				return;
			end
			want = pending_answers.pop_front();
			if (got.ancestor !== want.ancestor || got.is_answer !== want.is_answer) begin
				n_mismatch++;
				if (n_mismatch <= MAX_REPORTS)
					$display("ERROR: result %0d: expected ancestor=%0d is_answer=%0d, %s%0d %s%0d",
						n_checked, want.ancestor, want.is_answer,
						"got ancestor=", got.ancestor, "is_answer=", got.is_answer);
			end
		endfunction

		function int pending();
			return pending_answers.size();
		endfunction

	endclass

endpackage

/* tb/sv/tree_lca_binary_lifting_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lowest common ancestor testbench
// Builds trees through attach items, asks lowest common ancestor queries and
// checks every result against a scoreboard, under several idling patterns.
// ----------------------------------------------------------------------------
module tree_lca_binary_lifting_tb;

	import tlca_pkg::*;
	import tlca_tb_pkg::*;

	localparam int SETTLE_CYCLES = 4 * (2 * LIFT_LEVELS_DEF + 4);
	localparam int HOLD_CYCLES   = 400;
	localparam longint WATCHDOG_NS = 5_000_000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	lca_scoreboard sb;

	int src_idle_pct;
	int sink_stall_pct;
	int hold_len;
	int n_attach;
	int n_query;
	bit in_tree [NODE_COUNT_DEF];
	int tree_nodes [$];

	tree_lca_binary_lifting i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// Clock with a 10 ns period.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Both handshakes are sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp);
			if (req_valid && req_ready)
				sb.note_request(req);
		end
	end

	// The receiver stalls at random, or for a long stretch when asked.
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len != 0) begin
				rsp_ready <= 1'b0;
				hold_len--;
			end else begin
				rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// Offer one item and wait until it is taken.
	task automatic send_req(logic kind, int a, int b);
		req_t item;
		item.req_type = kind;
		item.node_a   = a[FIELD_W-1:0];
		item.node_b   = b[FIELD_W-1:0];
		if (kind == REQ_ATTACH) begin
			n_attach++;
			if (a != 0 && !in_tree[a]) begin
				in_tree[a] = 1'b1;
				tree_nodes = {tree_nodes, a};
			end
		end else begin
			n_query++;
		end
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
	endtask

	// Stop offering and wait until every result has come back.
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic int pick_tree_node();
		if (tree_nodes.size() == 0 || $urandom_range(9) == 0)
			return $urandom_range(0, 1023);
		return tree_nodes[$urandom_range(tree_nodes.size() - 1)];
	endfunction

	// Prefer a node that is not yet in the tree.
	function automatic int pick_fresh_child();
		int n;
		n = $urandom_range(1, 1023);
		for (int t = 0; t < 8 && in_tree[n]; t++)
			n = $urandom_range(1, 1023);
		return n;
	endfunction

	// Hand-picked items: sentinel, unattached nodes, a small tree and the odd cases.
	task automatic run_directed();
		send_req(REQ_QUERY, 0, 0);
		send_req(REQ_QUERY, 1023, 1023);
		send_req(REQ_QUERY, 5, 9);
		send_req(REQ_ATTACH, 1, 0);
		send_req(REQ_ATTACH, 2, 1);
		send_req(REQ_ATTACH, 3, 1);
		send_req(REQ_ATTACH, 4, 2);
		send_req(REQ_ATTACH, 1023, 4);
		send_req(REQ_QUERY, 1023, 3);
		send_req(REQ_QUERY, 3, 1023);
		send_req(REQ_QUERY, 4, 2);
		send_req(REQ_QUERY, 1023, 1023);
		// Attaching node zero leaves the sentinel alone.
		send_req(REQ_ATTACH, 0, 5);
		send_req(REQ_QUERY, 0, 4);
		// Re-attach: node 4 and below keep their stale rows.
		send_req(REQ_ATTACH, 2, 3);
		send_req(REQ_QUERY, 4, 3);
		// A node hung under itself, then a two-node cycle.
		send_req(REQ_ATTACH, 7, 7);
		send_req(REQ_QUERY, 7, 1);
		send_req(REQ_ATTACH, 8, 9);
		send_req(REQ_ATTACH, 9, 8);
		send_req(REQ_QUERY, 8, 9);
		send_req(REQ_QUERY, 9, 1023);
		send_req(REQ_ATTACH, 1022, 1023);
		send_req(REQ_ATTACH, 1023, 1023);
		send_req(REQ_QUERY, 1022, 0);
	endtask

	// Mostly well-formed tree building and queries, with some raw noise.
	task automatic run_mixed(int count);
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 45)
				send_req(REQ_ATTACH, pick_fresh_child(),
					(tree_nodes.size() != 0 && $urandom_range(9) != 0) ?
					tree_nodes[$urandom_range(tree_nodes.size() - 1)] : 0);
			else if (r < 85)
				send_req(REQ_QUERY, pick_tree_node(), pick_tree_node());
			else
				send_req(1'($urandom_range(1)), $urandom_range(0, 1023),
					$urandom_range(0, 1023));
		end
	endtask

	// One long chain drives the depth to saturation and uses every lifting level.
	task automatic run_deep_chain(int length);
		int cur;
		int child;
		int chain [$];
		cur = 0;
		for (int n = 0; n < length; n++) begin
			child = $urandom_range(1, 1023);
			send_req(REQ_ATTACH, child, cur);
			chain = {chain, child};
			cur = child;
			if ($urandom_range(9) == 0)
				send_req(REQ_QUERY, chain[$urandom_range(chain.size() - 1)],
					chain[$urandom_range(chain.size() - 1)]);
		end
		repeat (10)
			send_req(REQ_QUERY, cur, chain[$urandom_range(chain.size() - 1)]);
	endtask

	// Main sequence of phases.
	initial begin
		sb             = new();
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req            = '0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_len       = 0;
		n_attach       = 0;
		n_query        = 0;
		for (int n = 0; n < NODE_COUNT_DEF; n++)
			in_tree[n] = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		drain();

		// No idling on either side.
		run_mixed(170);
		drain();

		// Sender idle most of the time.
		src_idle_pct = 60;
		run_mixed(170);
		drain();

		// Receiver stalling, opened by a long hold-off that backs up the input.
		src_idle_pct   = 0;
		sink_stall_pct = 60;
		hold_len       = HOLD_CYCLES;
		run_mixed(170);
		drain();

		// Light idling on both sides.
		src_idle_pct   = 20;
		sink_stall_pct = 20;
		run_mixed(170);
		drain();
		run_deep_chain(1030);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d attach and %0d query items, %0d results checked, %0d mismatches.",
			n_attach, n_query, sb.n_checked, sb.n_mismatch);
		$display("Idling patterns: none, sender, receiver with long hold-off, both; depth %0d.",
			sb.deepest);
		if (sb.n_mismatch == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#(WATCHDOG_NS);
		$display("ERROR: timeout with %0d results outstanding", sb.pending());
		$display("== FAIL ==");
		$finish;
	end

endmodule
